// ===== sv/nbi_pkg.sv =====
package nbi_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ZERO_SP = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] query_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [4:0]         points_held;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_COPY,
    S_COPY_WAIT,
    S_DIFF_RD,
    S_DIFF_WR,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_ACC,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // store the sample
    logic clear;
    logic eval_init;   // latch query, start divider
    logic copy_wr;     // write diff_work at idx from y read
    logic diff_wr;     // write diff_work[j]
    logic mul_a;       // p *= (u + i - 1)
    logic mul_b;       // p *= recip(i)
    logic mul_c;       // t = p * diff[n-1]
    logic acc;         // sum += t
    logic sum_init;    // sum = y[n-1], p = 1
  } ctl_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic flag);
    flag = 1'b0;
    if (v > 66'sd2147483647) begin
      flag = 1'b1;
      return SMAX;
    end
    if (v < -66'sd2147483648) begin
      flag = 1'b1;
      return SMIN;
    end
    return v[31:0];
  endfunction

endpackage

// ===== sv/newton_backward_interpolator_core.sv =====
// channel | direction | handshake          | payload
// in      | into core | start, busy        | in_item
// out     | from core | done (one strobe)  | out_item
// load, clear, unused command and early evaluate answers strobe in the cycle after start
// full evaluate of n points strobes after the serial divider (49 steps), a copy of the
// samples, a read and a write per difference and three products and an add per sum term
// rst is synchronous and clears the point count, x registers and state
// results cannot be stalled; busy falls in the cycle of the result strobe
module newton_backward_interpolator_core #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  nbi_pkg::in_item_t   in_item,
  output logic                busy,
  output logic                done,
  output nbi_pkg::out_item_t  out_item
);
  localparam int CW = $clog2(MAX_POINTS + 1);

  nbi_pkg::ctl_t      ctl;
  nbi_pkg::sts_t      sts;
  logic [CW-1:0]      idx, iter, count;
  logic signed [31:0] y_first, sum;
  logic               sat, spacing_zero;

  nbi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .item(in_item), .sts(sts),
    .spacing_zero(spacing_zero), .y_first(y_first), .sum(sum), .sat(sat),
    .busy(busy), .ctl(ctl), .idx(idx), .iter(iter), .count(count),
    .done(done), .result(out_item));

  nbi_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .item(in_item), .idx(idx), .iter(iter),
    .count(count), .sts(sts), .y_first(y_first), .sum(sum), .sat(sat),
    .spacing_zero(spacing_zero));
endmodule

// ===== sv/nbi_ram.sv =====
module nbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/nbi_div.sv =====
// restoring divider, one quotient bit a cycle, truncating toward zero
module nbi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,   // q - last_x
  input  logic signed [32:0] den,   // spacing
  output logic               done,
  output logic signed [31:0] quo,
  output logic               ovf
);
  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [NW-1:0] q;
  logic [33:0]   rem;
  logic [32:0]   dvs;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [33:0]   shifted;
  logic [NW:0]   mag;
  logic          sat_flag;
  logic signed [65:0] wide;

  always_comb begin
    shifted = {rem[32:0], dvd[NW-1]};
    mag = neg ? -{1'b0, q} : {1'b0, q};
    wide = 66'(signed'(mag));
    quo = nbi_pkg::sat32(wide, sat_flag);
    ovf = sat_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        dvd  <= NW'(num[32] ? -num : num) << FRAC_BITS;
        dvs  <= den[32] ? 33'(-den) : 33'(den);
        neg  <= num[32] ^ den[32];
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (shifted >= {1'b0, dvs}) begin
          rem <= shifted - {1'b0, dvs};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) busy <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/nbi_datapath.sv =====
module nbi_datapath #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int IW         = $clog2(MAX_POINTS),
  parameter int CW         = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  nbi_pkg::ctl_t      ctl,
  input  nbi_pkg::in_item_t  item,
  input  logic [CW-1:0]      idx,    // copy index or diff j
  input  logic [CW-1:0]      iter,   // i
  input  logic [CW-1:0]      count,
  output nbi_pkg::sts_t      sts,
  output logic signed [31:0] y_first,
  output logic signed [31:0] sum,
  output logic               sat,
  output logic               spacing_zero
);
  localparam logic signed [65:0] ONE  = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [31:0] first_x, second_x, last_x;
  logic signed [31:0] u, p, t;
  logic               div_done, div_ovf;
  logic signed [31:0] div_q;

  // y store
  logic [IW-1:0] y_waddr, y_raddr;
  logic [31:0]   y_rdata;
  // difference store: two copies so j and j-1 read together
  logic          d_we;
  logic [IW-1:0] d_waddr, d_ra, d_rb;
  logic [31:0]   d_wdata, d_qa, d_qb;
  logic [31:0]   y0;

  assign y_waddr = count[IW-1:0];
  assign y_raddr = idx[IW-1:0];

  nbi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y (
    .clk(clk), .we(ctl.load), .waddr(y_waddr), .wdata(item.sample_y),
    .raddr(y_raddr), .rdata(y_rdata));

  logic [CW-1:0] jm1;
  assign jm1  = idx - CW'(1);
  // idx holds n-1 through the products, so port a then reads diff[n-1]
  assign d_ra = idx[IW-1:0];
  assign d_rb = jm1[IW-1:0];

  nbi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_da (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_ra), .rdata(d_qa));
  nbi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_db (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_rb), .rdata(d_qb));

  logic signed [31:0] diff_sat;
  logic               diff_f;
  always_comb begin
    diff_sat = nbi_pkg::sat32(66'(signed'(d_qa)) - 66'(signed'(d_qb)), diff_f);
    d_we     = ctl.copy_wr | ctl.diff_wr;
    d_waddr  = idx[IW-1:0];
    d_wdata  = ctl.copy_wr ? y_rdata : diff_sat;
  end

  nbi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(ctl.eval_init),
    .num(33'(item.query_point) - 33'(last_x)),
    .den(33'(second_x) - 33'(first_x)),
    .done(div_done), .quo(div_q), .ovf(div_ovf));
  assign sts.div_done = div_done;

  assign spacing_zero = (second_x == first_x);
  assign y_first      = y0;

  // shared multiplier operands
  logic signed [31:0] ma, mb;
  logic signed [65:0] prod, rnd;
  logic signed [31:0] mres;
  logic               mf;
  logic signed [31:0] ui;
  logic               uf;
  logic signed [31:0] rcp;

  function automatic logic signed [65:0] floor_sh(input logic signed [65:0] a);
    return a >>> FRAC_BITS;
  endfunction

  // reciprocal round(2^F / k) from a constant table
  function automatic logic signed [31:0] recip(input logic [CW-1:0] k);
    logic [63:0] one;
    one = 64'd1 << FRAC_BITS;
    return 32'((one + 64'(k >> 1)) / 64'(k));
  endfunction

  logic signed [31:0] rtab [MAX_POINTS];
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      rtab[k] = (k == 0) ? 32'sd0 : recip(CW'(k));
    end
  end

  always_comb begin
    rcp = rtab[iter[IW-1:0]];
    ui  = nbi_pkg::sat32(66'(u) +
                         (66'(signed'({1'b0, iter} - (CW+1)'(1))) <<< FRAC_BITS), uf);
    ma  = p;
    mb  = ctl.mul_a ? ui : (ctl.mul_b ? rcp : d_qa);
    prod = 66'(ma) * 66'(mb);
    rnd  = prod + HALF;
    mres = nbi_pkg::sat32(floor_sh(rnd), mf);
  end

  logic signed [31:0] acc_res;
  logic               acc_f;
  always_comb begin
    acc_res = nbi_pkg::sat32(66'(sum) + 66'(t), acc_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0;
      second_x <= '0;
      last_x <= '0;
    end else if (ctl.clear) begin
      first_x <= '0;
      second_x <= '0;
      last_x <= '0;
    end else if (ctl.load) begin
      if (count == '0) first_x <= item.sample_x;
      if (count == CW'(1)) second_x <= item.sample_x;
      last_x <= item.sample_x;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && count == '0) y0 <= item.sample_y;
    if (ctl.eval_init) sat <= 1'b0;
    if (div_done) begin
      u <= div_q;
      if (div_ovf) sat <= 1'b1;
    end
    if (ctl.diff_wr && diff_f) sat <= 1'b1;
    if (ctl.sum_init) begin
      sum <= y_rdata;
      p   <= ONE[31:0];
    end
    if (ctl.mul_a) begin
      p <= mres;
      if (mf || uf) sat <= 1'b1;
    end
    if (ctl.mul_b) begin
      p <= mres;
      if (mf) sat <= 1'b1;
    end
    if (ctl.mul_c) begin
      t <= mres;
      if (mf) sat <= 1'b1;
    end
    if (ctl.acc) begin
      sum <= acc_res;
      if (acc_f) sat <= 1'b1;
    end
  end
endmodule

// ===== sv/nbi_ctrl.sv =====
module nbi_ctrl #(
  parameter int MAX_POINTS = 16,
  parameter int CW         = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  nbi_pkg::in_item_t  item,
  input  nbi_pkg::sts_t      sts,
  input  logic               spacing_zero,
  input  logic signed [31:0] y_first,
  input  logic signed [31:0] sum,
  input  logic               sat,
  output logic               busy,
  output nbi_pkg::ctl_t      ctl,
  output logic [CW-1:0]      idx,
  output logic [CW-1:0]      iter,
  output logic [CW-1:0]      count,
  output logic               done,
  output nbi_pkg::out_item_t result
);
  nbi_pkg::state_t state, state_next;
  logic [CW-1:0] idx_next, iter_next, count_next;
  logic [CW-1:0] last_idx;
  logic          done_next;
  nbi_pkg::out_item_t result_next;
  logic          accept;

  assign accept   = start && !busy;
  assign busy     = (state != nbi_pkg::S_IDLE);
  assign last_idx = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nbi_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx    <= idx_next;
    iter   <= iter_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    iter_next   = iter;
    count_next  = count;
    done_next   = 1'b0;
    result_next = result;
    ctl         = '0;
    unique case (state)
      nbi_pkg::S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          result_next = '0;
          unique case (nbi_pkg::cmd_t'(item.cmd))
            nbi_pkg::CMD_LOAD: begin
              if (count >= CW'(MAX_POINTS)) begin
                result_next.status = nbi_pkg::ST_FULL;
                result_next.points_held = 5'(count);
              end else begin
                ctl.load = 1'b1;
                count_next = count + CW'(1);
                result_next.points_held = 5'(count + CW'(1));
              end
            end
            nbi_pkg::CMD_EVAL: begin
              result_next.points_held = 5'(count);
              if (count == '0) begin
                result_next.status = nbi_pkg::ST_EMPTY;
              end else if (count == CW'(1)) begin
                result_next.value = y_first;
              end else if (spacing_zero) begin
                result_next.status = nbi_pkg::ST_ZERO_SP;
              end else begin
                done_next = 1'b0;
                ctl.eval_init = 1'b1;
                state_next = nbi_pkg::S_DIV;
              end
            end
            nbi_pkg::CMD_CLEAR: begin
              ctl.clear = 1'b1;
              count_next = '0;
            end
            default: result_next.points_held = 5'(count);
          endcase
        end
      end
      nbi_pkg::S_DIV: begin
        if (sts.div_done) begin
          idx_next = '0;
          state_next = nbi_pkg::S_COPY;
        end
      end
      nbi_pkg::S_COPY: state_next = nbi_pkg::S_COPY_WAIT;
      nbi_pkg::S_COPY_WAIT: begin
        ctl.copy_wr = 1'b1;
        if (idx == last_idx) begin
          // y[n-1] is on the read port now, seed the sum with it
          ctl.sum_init = 1'b1;
          iter_next = CW'(1);
          state_next = nbi_pkg::S_DIFF_RD;
        end else begin
          idx_next = idx + CW'(1);
          state_next = nbi_pkg::S_COPY;
        end
      end
      nbi_pkg::S_DIFF_RD: state_next = nbi_pkg::S_DIFF_WR;
      nbi_pkg::S_DIFF_WR: begin
        ctl.diff_wr = 1'b1;
        if (idx == iter) begin
          idx_next = last_idx;
          state_next = nbi_pkg::S_MUL_A;
        end else begin
          idx_next = idx - CW'(1);
          state_next = nbi_pkg::S_DIFF_RD;
        end
      end
      nbi_pkg::S_MUL_A: begin
        ctl.mul_a = 1'b1;
        state_next = nbi_pkg::S_MUL_B;
      end
      nbi_pkg::S_MUL_B: begin
        ctl.mul_b = 1'b1;
        state_next = nbi_pkg::S_MUL_C;
      end
      nbi_pkg::S_MUL_C: begin
        ctl.mul_c = 1'b1;
        state_next = nbi_pkg::S_ACC;
      end
      nbi_pkg::S_ACC: begin
        ctl.acc = 1'b1;
        if (iter == last_idx) begin
          state_next = nbi_pkg::S_DONE;
        end else begin
          iter_next = iter + CW'(1);
          state_next = nbi_pkg::S_DIFF_RD;
        end
      end
      nbi_pkg::S_DONE: begin
        done_next = 1'b1;
        result_next.value = sum;
        result_next.status = sat ? nbi_pkg::ST_SAT : nbi_pkg::ST_OK;
        result_next.points_held = 5'(count);
        state_next = nbi_pkg::S_IDLE;
      end
      default: state_next = nbi_pkg::S_IDLE;
    endcase
  end
endmodule

// ===== sv/nbi_checker.sv =====
module nbi_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input nbi_pkg::out_item_t out_item
);
  a_start_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("accepted beat lost");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> out_item.status <= nbi_pkg::ST_SAT) else $error("status out of range");
  a_err_val: assert property (@(posedge clk) disable iff (rst)
    done && out_item.status != nbi_pkg::ST_OK && out_item.status != nbi_pkg::ST_SAT
    |-> out_item.value == 32'd0) else $error("error result carries a value");
endmodule

bind newton_backward_interpolator_core nbi_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .out_item(out_item));

// ===== dv/tb_newton_backward_interpolator_core.sv =====
`timescale 1ns / 1ps

module tb_newton_backward_interpolator_core;

  localparam int NPTS = 16;
  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS = 1650;

  class interp_scoreboard;
    nbi_pkg::out_item_t pending_results[$];
    logic signed [31:0] x_first, x_second, x_last;
    logic signed [31:0] ys[NPTS];
    int count;
    int mismatches;

    function new();
      x_first = 0;
      x_second = 0;
      x_last = 0;
      count = 0;
      mismatches = 0;
      foreach (ys[k]) ys[k] = 0;
    endfunction

    function longint clip(longint v, inout bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // rounded fixed-point product, ties toward +inf
    function longint qmul(longint a, longint b, inout bit f);
      longint prod;
      prod = a * b + (64'sd1 <<< (FB - 1));
      return clip(prod >>> FB, f);
    endfunction

    function nbi_pkg::out_item_t interpolate(longint q);
      nbi_pkg::out_item_t r;
      longint spacing, u, p, sum, one, num;
      longint d[NPTS];
      bit f;
      f = 0;
      r = '0;
      r.points_held = count[4:0];
      if (count == 0) begin
        r.status = nbi_pkg::ST_EMPTY;
        return r;
      end
      if (count == 1) begin
        r.value = ys[0];
        return r;
      end
      spacing = longint'(x_second) - longint'(x_first);
      if (spacing == 0) begin
        r.status = nbi_pkg::ST_ZERO_SP;
        return r;
      end
      one = 64'sd1 <<< FB;
      num = (q - longint'(x_last)) * one;
      u = clip(num / spacing, f);
      for (int j = 0; j < count; j++) d[j] = ys[j];
      sum = d[count - 1];
      p = one;
      for (int i = 1; i < count; i++) begin
        for (int j = count - 1; j >= i; j--) d[j] = clip(d[j] - d[j - 1], f);
        p = qmul(p, clip(u + longint'(i - 1) * one, f), f);
        p = qmul(p, (one + i / 2) / i, f);
        sum = clip(sum + qmul(p, d[count - 1], f), f);
      end
      r.value = sum[31:0];
      r.status = f ? nbi_pkg::ST_SAT : nbi_pkg::ST_OK;
      return r;
    endfunction

    function void note_input(nbi_pkg::in_item_t it);
      nbi_pkg::out_item_t r;
      r = '0;
      case (it.cmd)
        nbi_pkg::CMD_LOAD: begin
          if (count >= NPTS) begin
            r.status = nbi_pkg::ST_FULL;
          end else begin
            if (count == 0) x_first = it.sample_x;
            if (count == 1) x_second = it.sample_x;
            x_last = it.sample_x;
            ys[count] = it.sample_y;
            count++;
          end
          r.points_held = count[4:0];
        end
        nbi_pkg::CMD_EVAL: r = interpolate(longint'(it.query_point));
        nbi_pkg::CMD_CLEAR: begin
          count = 0;
          x_first = 0;
          x_second = 0;
          x_last = 0;
          r.points_held = 0;
        end
        default: r.points_held = count[4:0];
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(nbi_pkg::out_item_t got);
      nbi_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value || got.status !== want.status ||
          got.points_held !== want.points_held) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp value %h status %0d held %0d, %s %h status %0d held %0d",
                   want.value, want.status, want.points_held, "got value",
                   got.value, got.status, got.points_held);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  nbi_pkg::in_item_t in_item = '0;
  logic busy, done;
  nbi_pkg::out_item_t out_item;
  interp_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;

  newton_backward_interpolator_core uut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(out_item);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("newton_backward_interpolator_core verification failed");
        $finish;
      end
    end
  end

  // start stays high into the next beat when there is no gap
  task automatic send_beat(nbi_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  task automatic send_cmd(nbi_pkg::cmd_t c, logic [31:0] sx, logic [31:0] sy,
                          logic [31:0] q);
    nbi_pkg::in_item_t it;
    it.cmd = c;
    it.sample_x = sx;
    it.sample_y = sy;
    it.query_point = q;
    send_beat(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0006ffff) - 32'h00030000;
    endcase
  endfunction

  // equally spaced table of small random size, then a few queries and at times a random command
  task automatic random_set();
    int npts;
    logic signed [31:0] x0, h;
    npts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 6);
    x0 = $urandom_range(0, 32'h00100000) - 32'h00080000;
    h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 32'h00030000);
    if ($urandom_range(0, 1)) h = -h;
    send_cmd(nbi_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
    for (int k = 0; k < npts; k++)
      send_cmd(nbi_pkg::CMD_LOAD, x0 + k * h, rand_word(), $urandom);
    repeat ($urandom_range(1, 3))
      send_cmd(nbi_pkg::CMD_EVAL, $urandom, $urandom,
               ($urandom_range(0, 3) == 0) ? rand_word()
               : x0 + $urandom_range(0, 32'h00060000) - 32'h00030000);
    if ($urandom_range(0, 7) == 0)
      send_cmd(nbi_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_cmd(nbi_pkg::CMD_EVAL, 0, 0, 32'h00010000);
    send_cmd(nbi_pkg::CMD_LOAD, 32'h00010000, 32'h7fffffff, 0);
    send_cmd(nbi_pkg::CMD_EVAL, 0, 0, 32'h80000000);
    send_cmd(nbi_pkg::CMD_LOAD, 32'h00010000, 32'h80000000, 0);
    send_cmd(nbi_pkg::CMD_EVAL, 0, 0, 32'h00020000);
    send_cmd(nbi_pkg::CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_cmd(nbi_pkg::CMD_CLEAR, 0, 0, 0);
    send_cmd(nbi_pkg::CMD_LOAD, 32'h00010000, 32'h00010000, 0);
    send_cmd(nbi_pkg::CMD_LOAD, 32'h00020000, 32'h00040000, 0);
    send_cmd(nbi_pkg::CMD_LOAD, 32'h00030000, 32'h00090000, 0);
    send_cmd(nbi_pkg::CMD_EVAL, 0, 0, 32'h00028000);
    send_cmd(nbi_pkg::CMD_EVAL, 0, 0, 32'h7fffffff);
    send_cmd(nbi_pkg::CMD_CLEAR, 0, 0, 0);
    for (int k = 0; k < NPTS + 1; k++)
      send_cmd(nbi_pkg::CMD_LOAD, k * 32'h00010000,
               (k & 1) ? 32'h7fffffff : 32'h80000000, 0);
    send_cmd(nbi_pkg::CMD_EVAL, 0, 0, 32'h00108000);
    while (sent < RAND_ITEMS) random_set();
    start <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("newton_backward_interpolator_core verification clean");
    else
      $display("newton_backward_interpolator_core verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
sv/nbi_pkg.sv
sv/nbi_ram.sv
sv/nbi_div.sv
sv/nbi_datapath.sv
sv/nbi_ctrl.sv
sv/newton_backward_interpolator_core.sv
sv/nbi_checker.sv
dv/tb_newton_backward_interpolator_core.sv
